// File: hdl/fel_pkg.sv
// Package for the float exp/log/pow pipeline: types, constants, float arithmetic and program.
`timescale 1ns / 1ps
package fel_pkg;

    // Pipeline geometry.
    localparam int NSTAGE = 55;
    localparam int NREG   = 5;
    localparam int SW     = 50;

    typedef logic [31:0] t_word;

    // Command codes.
    localparam logic [1:0] CMD_EXP = 2'd0;
    localparam logic [1:0] CMD_LOG = 2'd1;
    localparam logic [1:0] CMD_POW = 2'd2;

    // Bit patterns of the constants.
    localparam t_word ALL_ONES  = 32'hFFFF_FFFF;
    localparam t_word QNAN_BITS = 32'h7FC0_0000;
    localparam t_word PINF_BITS = 32'h7F80_0000;
    localparam t_word F_ONE     = 32'h3F80_0000;
    localparam t_word F_MONE    = 32'hBF80_0000;
    localparam t_word F_HALF    = 32'h3F00_0000;
    localparam t_word F_ZERO    = 32'h0000_0000;
    localparam t_word EXP_HI    = 32'h42B0_C0A5;
    localparam t_word EXP_LO    = 32'hC2B0_C0A5;
    localparam t_word LOG2E     = 32'h3FB8_AA3B;
    localparam t_word RED_C1    = 32'h3F31_8000;
    localparam t_word RED_C2    = 32'hB95E_8083;
    localparam t_word SQRT_HALF = 32'h3F35_04F3;
    localparam t_word EP0 = 32'h3950_6967;
    localparam t_word EP1 = 32'h3AB7_43CE;
    localparam t_word EP2 = 32'h3C08_8908;
    localparam t_word EP3 = 32'h3D2A_A9C1;
    localparam t_word EP4 = 32'h3E2A_AAAA;
    localparam t_word EP5 = 32'h3F00_0000;
    localparam t_word LP0 = 32'h3D90_21BB;
    localparam t_word LP1 = 32'hBDEB_D1B8;
    localparam t_word LP2 = 32'h3DEF_251A;
    localparam t_word LP3 = 32'hBDFE_5D4F;
    localparam t_word LP4 = 32'h3E11_E9BF;
    localparam t_word LP5 = 32'hBE2A_AE50;
    localparam t_word LP6 = 32'h3E4C_CEAC;
    localparam t_word LP7 = 32'hBE7F_FFFC;
    localparam t_word LP8 = 32'h3EAA_AAAA;

    // Stage operations and operand sources.
    typedef enum logic [2:0] {
        OP_ADD, OP_MUL, OP_FLOOR, OP_LOGOUT, OP_EXPIN, OP_FINAL
    } t_op;

    typedef enum logic [2:0] {
        SRC_X, SRC_Y, SRC_Z, SRC_T, SRC_U, SRC_K, SRC_B, SRC_P2N
    } t_src;

    typedef struct packed {
        t_op   op;
        t_src  dst;
        t_src  sa;
        t_src  sb;
        logic  negb;
        t_word k;
    } t_instr;

    // Everything that travels with one transaction down the pipeline.
    typedef struct packed {
        logic [1:0]              cmd;
        t_word                   a;
        t_word                   b;
        logic                    last;
        logic                    lspec;
        logic                    linf;
        logic                    enan;
        logic signed [9:0]       n;
        t_word [NREG-1:0]        regs;
    } t_slot;

    // Normalize, round to nearest even and pack. Value is s / 2^(SW-1) * 2^(e-127).
    function automatic t_word fp_pack(input logic sgn, input logic signed [10:0] e,
                                      input logic [SW-1:0] s);
        logic [5:0]         lz;
        logic [SW-1:0]      sn;
        logic [SW-1:0]      sd;
        logic signed [10:0] en;
        logic signed [10:0] sh;
        logic               lost;
        logic               g;
        logic               st;
        logic               rup;
        logic [23:0]        m;
        logic [7:0]         fe;
        logic [30:0]        mag;
        lz = '0;
        for (int i = 0; i < SW; i++) begin
            if (s[i]) lz = 6'(SW - 1 - i);
        end
        sn   = s << lz;
        en   = e - $signed({5'b0, lz});
        sd   = sn;
        lost = 1'b0;
        fe   = en[7:0];
        // Results below the normal range shift right into the subnormal field.
        if (en <= 11'sd0) begin
            sh = 11'sd1 - en;
            fe = '0;
            if (sh >= $signed(11'(SW))) begin
                sd   = '0;
                lost = |sn;
            end else begin
                sd   = sn >> sh[5:0];
                lost = |(sn << (6'(SW) - sh[5:0]));
            end
        end
        m   = sd[SW-1 -: 24];
        g   = sd[SW-25];
        st  = (|sd[SW-26:0]) | lost;
        rup = g & (st | m[0]);
        mag = {fe, m[22:0]} + 31'(rup);
        if (s == '0) return {sgn, 31'b0};
        if (en >= 11'sd255) return {sgn, 8'hFF, 23'b0};
        return {sgn, mag};
    endfunction

    // Single-precision addition.
    function automatic t_word fp_add(input t_word a, input t_word b);
        logic               swp;
        logic               sl;
        logic               sub;
        logic               st;
        logic [7:0]         el;
        logic [7:0]         es;
        logic [7:0]         d;
        logic [23:0]        ml;
        logic [23:0]        ms;
        logic [SW-1:0]      xl;
        logic [SW-1:0]      xs;
        logic [SW-1:0]      sum;
        if ((a[30:23] == 8'hFF && a[22:0] != '0) || (b[30:23] == 8'hFF && b[22:0] != '0))
            return QNAN_BITS;
        if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return QNAN_BITS;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:23] == 8'hFF) return b;
        swp = a[30:0] < b[30:0];
        sl  = swp ? b[31] : a[31];
        sub = a[31] != b[31];
        el  = swp ? b[30:23] : a[30:23];
        es  = swp ? a[30:23] : b[30:23];
        ml  = swp ? {b[30:23] != '0, b[22:0]} : {a[30:23] != '0, a[22:0]};
        ms  = swp ? {a[30:23] != '0, a[22:0]} : {b[30:23] != '0, b[22:0]};
        if (el == '0) el = 8'd1;
        if (es == '0) es = 8'd1;
        d  = el - es;
        xl = {1'b0, ml, 25'b0};
        xs = {1'b0, ms, 25'b0};
        // Align the smaller operand and keep a sticky bit of what falls off.
        if (d >= 8'd50) begin
            st = |ms;
            xs = '0;
        end else begin
            st = |(xs << (6'(SW) - d[5:0]));
            xs = xs >> d[5:0];
        end
        xs[0] = xs[0] | st;
        sum   = sub ? (xl - xs) : (xl + xs);
        return fp_pack((sub && sum == '0) ? 1'b0 : sl, $signed({3'b0, el}) + 11'sd1, sum);
    endfunction

    // Single-precision multiplication.
    function automatic t_word fp_mul(input t_word a, input t_word b);
        logic        sgn;
        logic        za;
        logic        zb;
        logic        ia;
        logic        ib;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [47:0] p;
        sgn = a[31] ^ b[31];
        ia  = a[30:23] == 8'hFF;
        ib  = b[30:23] == 8'hFF;
        za  = a[30:0] == '0;
        zb  = b[30:0] == '0;
        if ((ia && a[22:0] != '0) || (ib && b[22:0] != '0)) return QNAN_BITS;
        if ((ia && zb) || (za && ib)) return QNAN_BITS;
        if (ia || ib) return {sgn, 8'hFF, 23'b0};
        if (za || zb) return {sgn, 31'b0};
        ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
        p  = 48'({a[30:23] != '0, a[22:0]}) * 48'({b[30:23] != '0, b[22:0]});
        return fp_pack(sgn, $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126, {p, 2'b0});
    endfunction

    // Floor of a float of small magnitude as a signed integer.
    function automatic logic signed [9:0] fp_floor(input t_word v);
        logic [7:0]  e;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] ip;
        logic        frac;
        logic [9:0]  mag;
        e = v[30:23];
        m = {1'b1, v[22:0]};
        if (e < 8'd127) return (v[31] && v[30:0] != '0) ? -10'sd1 : 10'sd0;
        if (e > 8'd135) return 10'sd0;
        sh   = 5'(8'd150 - e);
        ip   = m >> sh;
        frac = |(m << (5'd24 - sh));
        mag  = ip[9:0];
        if (v[31]) return $signed(10'd0 - mag - 10'(frac));
        return $signed(mag);
    endfunction

    // Exact conversion of a small signed integer to a float.
    function automatic t_word fp_from_int(input logic signed [9:0] n);
        logic [9:0]  mag;
        logic [3:0]  pos;
        logic [22:0] fr;
        mag = n[9] ? (10'd0 - 10'(n)) : 10'(n);
        pos = '0;
        for (int i = 0; i < 10; i++) begin
            if (mag[i]) pos = 4'(i);
        end
        fr = 23'({13'b0, mag} << (5'd23 - 5'(pos)));
        if (n == 10'sd0) return F_ZERO;
        return {n[9], 8'd127 + 8'(pos), fr};
    endfunction

    // Power of two 2^n built in the exponent field, clamped to the field range.
    function automatic t_word fp_pow2(input logic signed [9:0] n);
        logic signed [10:0] bi;
        bi = $signed({n[9], n}) + 11'sd127;
        if (bi < 11'sd0) bi = 11'sd0;
        if (bi > 11'sd255) bi = 11'sd255;
        return {1'b0, bi[7:0], 23'b0};
    endfunction

    // Ordering key: unsigned compare of keys matches float compare.
    function automatic t_word fp_key(input t_word w);
        return w[31] ? ~w : {1'b1, w[30:0]};
    endfunction

    function automatic t_instr mk(input t_op op, input t_src dst, input t_src sa,
                                  input t_src sb, input logic negb, input t_word k);
        t_instr r;
        r.op   = op;
        r.dst  = dst;
        r.sa   = sa;
        r.sb   = sb;
        r.negb = negb;
        r.k    = k;
        return r;
    endfunction

    // Operation of each pipeline stage: log part, pow product, exp part, then the final result select.
    function automatic t_instr fel_prog(input logic [5:0] idx);
        t_instr r;
        unique case (idx)
            6'd0:  r = mk(OP_ADD, SRC_X, SRC_X, SRC_K, 1'b0, F_MONE);
            6'd1:  r = mk(OP_ADD, SRC_U, SRC_U, SRC_Y, 1'b1, F_ZERO);
            6'd2:  r = mk(OP_ADD, SRC_X, SRC_X, SRC_Z, 1'b0, F_ZERO);
            6'd3:  r = mk(OP_MUL, SRC_Z, SRC_X, SRC_X, 1'b0, F_ZERO);
            6'd4:  r = mk(OP_MUL, SRC_Y, SRC_X, SRC_K, 1'b0, LP0);
            6'd5:  r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP1);
            6'd6:  r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd7:  r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP2);
            6'd8:  r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd9:  r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP3);
            6'd10: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd11: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP4);
            6'd12: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd13: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP5);
            6'd14: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd15: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP6);
            6'd16: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd17: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP7);
            6'd18: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd19: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, LP8);
            6'd20: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd21: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_Z, 1'b0, F_ZERO);
            6'd22: r = mk(OP_MUL, SRC_T, SRC_U, SRC_K, 1'b0, RED_C2);
            6'd23: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_T, 1'b0, F_ZERO);
            6'd24: r = mk(OP_MUL, SRC_T, SRC_Z, SRC_K, 1'b0, F_HALF);
            6'd25: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_T, 1'b1, F_ZERO);
            6'd26: r = mk(OP_ADD, SRC_X, SRC_X, SRC_Y, 1'b0, F_ZERO);
            6'd27: r = mk(OP_MUL, SRC_T, SRC_U, SRC_K, 1'b0, RED_C1);
            6'd28: r = mk(OP_ADD, SRC_X, SRC_X, SRC_T, 1'b0, F_ZERO);
            6'd29: r = mk(OP_LOGOUT, SRC_U, SRC_X, SRC_X, 1'b0, F_ZERO);
            6'd30: r = mk(OP_MUL, SRC_X, SRC_U, SRC_B, 1'b0, F_ZERO);
            6'd31: r = mk(OP_EXPIN, SRC_X, SRC_X, SRC_X, 1'b0, F_ZERO);
            6'd32: r = mk(OP_MUL, SRC_T, SRC_X, SRC_K, 1'b0, LOG2E);
            6'd33: r = mk(OP_ADD, SRC_T, SRC_T, SRC_K, 1'b0, F_HALF);
            6'd34: r = mk(OP_FLOOR, SRC_T, SRC_T, SRC_T, 1'b0, F_ZERO);
            6'd35: r = mk(OP_MUL, SRC_Z, SRC_T, SRC_K, 1'b0, RED_C1);
            6'd36: r = mk(OP_ADD, SRC_X, SRC_X, SRC_Z, 1'b1, F_ZERO);
            6'd37: r = mk(OP_MUL, SRC_Z, SRC_T, SRC_K, 1'b0, RED_C2);
            6'd38: r = mk(OP_ADD, SRC_X, SRC_X, SRC_Z, 1'b1, F_ZERO);
            6'd39: r = mk(OP_MUL, SRC_Y, SRC_X, SRC_K, 1'b0, EP0);
            6'd40: r = mk(OP_MUL, SRC_Z, SRC_X, SRC_X, 1'b0, F_ZERO);
            6'd41: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, EP1);
            6'd42: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd43: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, EP2);
            6'd44: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd45: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, EP3);
            6'd46: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd47: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, EP4);
            6'd48: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd49: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, EP5);
            6'd50: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_Z, 1'b0, F_ZERO);
            6'd51: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_X, 1'b0, F_ZERO);
            6'd52: r = mk(OP_ADD, SRC_Y, SRC_Y, SRC_K, 1'b0, F_ONE);
            6'd53: r = mk(OP_MUL, SRC_Y, SRC_Y, SRC_P2N, 1'b0, F_ZERO);
            default: r = mk(OP_FINAL, SRC_X, SRC_X, SRC_X, 1'b0, F_ZERO);
        endcase
        return r;
    endfunction

endpackage

// File: hdl/fel_if.sv
// Valid/ready channel interfaces for the float exp/log/pow pipeline.
`timescale 1ns / 1ps
interface fel_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        last_in;

    modport source(output valid, command, operand_a, operand_b, last_in, input ready);
    modport sink(input valid, command, operand_a, operand_b, last_in, output ready);
endinterface

interface fel_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    logic        last_out;

    modport source(output valid, result_bits, last_out, input ready);
    modport sink(input valid, result_bits, last_out, output ready);
endinterface

// File: hdl/fel_entry.sv
// First pipeline stage: log argument split, special-case flags and initial registers.
`timescale 1ns / 1ps
module fel_entry (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [1:0]    i_cmd,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    input  logic          i_last,
    output logic          o_valid,
    output fel_pkg::t_slot o_slot
);
    import fel_pkg::*;

    logic              r_valid;
    t_slot             r_slot;
    t_slot             n_slot;
    logic [7:0]        w_field;
    t_word             w_x0;
    logic              w_small;
    logic signed [9:0] w_eint;

    // Mantissa in [0.5, 1) and the adjusted exponent for the log.
    always_comb begin
        w_field = i_a[30:23];
        w_x0    = {9'h07E, i_a[22:0]};
        w_small = w_x0 < SQRT_HALF;
        w_eint  = $signed({2'b0, w_field}) - 10'sd126;

        n_slot          = '0;
        n_slot.cmd      = i_cmd;
        n_slot.a        = i_a;
        n_slot.b        = i_b;
        n_slot.last     = i_last;
        n_slot.lspec    = i_a[31] || w_field == 8'h00 || w_field == 8'hFF;
        n_slot.linf     = !i_a[31] && w_field == 8'hFF && i_a[22:0] == '0;
        n_slot.regs[SRC_X] = w_x0;
        n_slot.regs[SRC_Y] = w_small ? F_ONE : F_ZERO;
        n_slot.regs[SRC_Z] = w_small ? w_x0 : F_ZERO;
        n_slot.regs[SRC_T] = F_ZERO;
        n_slot.regs[SRC_U] = fp_from_int(w_eint);
    end

    // Valid bit under reset; payload moves with the enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slot <= n_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;
endmodule

// File: hdl/fel_stage.sv
// One pipeline stage that applies a single float operation to the transaction's registers.
`timescale 1ns / 1ps
module fel_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fel_pkg::t_instr i_instr,
    input  logic            i_valid,
    input  fel_pkg::t_slot  i_slot,
    output logic            o_valid,
    output fel_pkg::t_slot  o_slot
);
    import fel_pkg::*;

    logic              r_valid;
    t_slot             r_slot;
    t_slot             n_slot;
    t_word             w_opa;
    t_word             w_opb;
    t_word             w_xs;
    logic signed [9:0] w_n;

    function automatic t_word pick(input t_slot s, input t_src c, input t_word k);
        t_word r;
        unique case (c)
            SRC_X:   r = s.regs[SRC_X];
            SRC_Y:   r = s.regs[SRC_Y];
            SRC_Z:   r = s.regs[SRC_Z];
            SRC_T:   r = s.regs[SRC_T];
            SRC_U:   r = s.regs[SRC_U];
            SRC_K:   r = k;
            SRC_B:   r = s.b;
            SRC_P2N: r = fp_pow2(s.n);
        endcase
        return r;
    endfunction

    // Operand selection and the stage's operation.
    always_comb begin
        n_slot = i_slot;
        w_opa  = pick(i_slot, i_instr.sa, i_instr.k);
        w_opb  = pick(i_slot, i_instr.sb, i_instr.k) ^ {i_instr.negb, 31'b0};
        w_xs   = (i_slot.cmd == CMD_EXP) ? i_slot.a : i_slot.regs[SRC_X];
        w_n    = fp_floor(w_opa);
        unique case (i_instr.op)
            OP_ADD: n_slot.regs[i_instr.dst] = fp_add(w_opa, w_opb);
            OP_MUL: n_slot.regs[i_instr.dst] = fp_mul(w_opa, w_opb);
            OP_FLOOR: begin
                n_slot.n                 = w_n;
                n_slot.regs[i_instr.dst] = fp_from_int(w_n);
            end
            OP_LOGOUT: begin
                n_slot.regs[i_instr.dst] = !i_slot.lspec ? i_slot.regs[SRC_X] :
                                           (i_slot.linf ? PINF_BITS : ALL_ONES);
            end
            OP_EXPIN: begin
                // Exp takes the operand, pow the product; then clamp to the exp range.
                n_slot.enan = w_xs[30:23] == 8'hFF && w_xs[22:0] != '0;
                if (fp_key(w_xs) > fp_key(EXP_HI)) begin
                    n_slot.regs[i_instr.dst] = EXP_HI;
                end else if (fp_key(w_xs) < fp_key(EXP_LO)) begin
                    n_slot.regs[i_instr.dst] = EXP_LO;
                end else begin
                    n_slot.regs[i_instr.dst] = w_xs;
                end
            end
            OP_FINAL: begin
                unique case (i_slot.cmd)
                    CMD_LOG: n_slot.regs[i_instr.dst] = i_slot.regs[SRC_U];
                    CMD_EXP, CMD_POW: begin
                        n_slot.regs[i_instr.dst] = i_slot.enan ? QNAN_BITS : i_slot.regs[SRC_Y];
                    end
                    default: n_slot.regs[i_instr.dst] = ALL_ONES;
                endcase
            end
            default: n_slot = i_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slot <= n_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;
endmodule

// File: hdl/float_exp_log_pow_unit.sv
// Throughput: one transaction per cycle while no result waits at the output.
// Each stage holds one float add or multiply, or a floor, clamp or select step.
// The whole pipeline advances together; it holds only while a result waits at the output.
// Reset clears the valid bit of every stage; payload registers are not reset.
// Top level of the float exp/log/pow pipeline.
`timescale 1ns / 1ps
module float_exp_log_pow_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fel_in_if.sink    i_in,
    fel_out_if.source o_out
);
    import fel_pkg::*;

    logic  w_en;
    logic  w_valid [0:NSTAGE];
    t_slot w_slot  [0:NSTAGE];

    // Global advance: move unless a finished result is still waiting.
    assign w_en       = o_out.ready || !w_valid[NSTAGE];
    assign i_in.ready = w_en;

    fel_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_cmd   (i_in.command),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .i_last  (i_in.last_in),
        .o_valid (w_valid[0]),
        .o_slot  (w_slot[0])
    );

    // Operation stages in program order.
    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        fel_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_instr (fel_prog(6'(k))),
            .i_valid (w_valid[k]),
            .i_slot  (w_slot[k]),
            .o_valid (w_valid[k+1]),
            .o_slot  (w_slot[k+1])
        );
    end

    assign o_out.valid       = w_valid[NSTAGE];
    assign o_out.result_bits = w_slot[NSTAGE].regs[SRC_X];
    assign o_out.last_out    = w_slot[NSTAGE].last;

`ifndef ASSERT_OFF
    // A waiting result stalls the input side.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // An accepted transaction reaches the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_valid[0])
        else $error("accepted transaction lost at entry");

    // Unused commands give the all-ones pattern.
    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && w_slot[NSTAGE].cmd != CMD_EXP && w_slot[NSTAGE].cmd != CMD_LOG &&
        w_slot[NSTAGE].cmd != CMD_POW |-> o_out.result_bits == ALL_ONES)
        else $error("unused command result wrong");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif
endmodule

// File: bench/testbench.sv
// Self-checking bench for the float exp/log/pow pipeline with a bit-exact float predictor.
`timescale 1ns / 1ps
module testbench;
    import fel_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PHASE_ITEMS    = 80;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam t_word NEG_ZERO = 32'h8000_0000;

    typedef struct packed {
        logic [1:0] command;
        t_word      operand_a;
        t_word      operand_b;
        logic       last_in;
    } t_request;

    typedef struct packed {
        t_word result_bits;
        logic  last_out;
    } t_answer;

    logic clk;
    logic rst_n;

    fel_in_if  in_ch();
    fel_out_if out_ch();

    float_exp_log_pow_unit dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_request pending_q[$];
    t_answer  answer_q[$];
    int       sent_count;
    int       mismatch_count;
    int       stall_cycles;
    bit       in_taken;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Round a value sig * 2^e2 to the nearest single, ties to even.
    function automatic t_word round_single(input logic sgn, input int e2,
                                           input logic [127:0] sig);
        int           p;
        int           ex;
        int           tgt;
        int           sh;
        logic [127:0] m;
        logic         g;
        logic         st;
        if (sig == '0) return {sgn, 31'b0};
        p = 0;
        for (int i = 0; i < 128; i++) begin
            if (sig[i]) p = i;
        end
        ex  = p + e2;
        tgt = (ex - 23 > -149) ? ex - 23 : -149;
        sh  = tgt - e2;
        if (sh <= 0) begin
            m = sig << (-sh);
            g = 1'b0;
            st = 1'b0;
        end else if (sh >= 129) begin
            m = '0;
            g = 1'b0;
            st = 1'b1;
        end else begin
            m  = sig >> sh;
            g  = sig[sh-1];
            st = (sh > 1) ? |(sig & ((128'b1 << (sh - 1)) - 1)) : 1'b0;
        end
        if (g && (st || m[0])) m = m + 1;
        if (m[24]) begin
            m = m >> 1;
            tgt++;
        end
        if (m[23]) begin
            if (tgt + 150 >= 255) return {sgn, 8'hFF, 23'b0};
            return {sgn, 8'(tgt + 150), m[22:0]};
        end
        return {sgn, 8'b0, m[22:0]};
    endfunction

    function automatic logic is_nan(input t_word w);
        return w[30:23] == 8'hFF && w[22:0] != '0;
    endfunction

    function automatic logic is_inf(input t_word w);
        return w[30:23] == 8'hFF && w[22:0] == '0;
    endfunction

    // Significand and scale of a finite single.
    function automatic void split_single(input t_word w, output logic [23:0] m, output int e2);
        if (w[30:23] == '0) begin
            m  = {1'b0, w[22:0]};
            e2 = -149;
        end else begin
            m  = {1'b1, w[22:0]};
            e2 = int'(w[30:23]) - 150;
        end
    endfunction

    function automatic real single_value(input t_word w);
        logic [23:0] m;
        int          e2;
        real         v;
        split_single(w, m, e2);
        v = real'(m) * (2.0 ** e2);
        return w[31] ? -v : v;
    endfunction

    function automatic t_word mul_single(input t_word a, input t_word b);
        logic        sgn;
        logic [23:0] ma;
        logic [23:0] mb;
        int          ea;
        int          eb;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN_BITS;
        if ((is_inf(a) && b[30:0] == '0) || (is_inf(b) && a[30:0] == '0)) return QNAN_BITS;
        if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'b0};
        if (a[30:0] == '0 || b[30:0] == '0) return {sgn, 31'b0};
        split_single(a, ma, ea);
        split_single(b, mb, eb);
        return round_single(sgn, ea + eb, {104'b0, ma} * {104'b0, mb});
    endfunction

    function automatic t_word add_single(input t_word a, input t_word b);
        t_word        big;
        t_word        lit;
        logic [23:0]  ml;
        logic [23:0]  ms;
        int           el;
        int           es;
        int           d;
        logic [127:0] xl;
        logic [127:0] xs;
        if (is_nan(a) || is_nan(b)) return QNAN_BITS;
        if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN_BITS : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == '0 && b[30:0] == '0) return (a[31] & b[31]) ? NEG_ZERO : F_ZERO;
        if (b[30:0] == '0) return a;
        if (a[30:0] == '0) return b;
        big = (a[30:23] >= b[30:23]) ? a : b;
        lit = (a[30:23] >= b[30:23]) ? b : a;
        split_single(big, ml, el);
        split_single(lit, ms, es);
        d  = el - es;
        xl = {104'b0, ml} << 60;
        xs = (d > 60) ? 128'd1 : (({104'b0, ms} << 60) >> d);
        if (big[31] == lit[31]) return round_single(big[31], el - 60, xl + xs);
        if (xl > xs) return round_single(big[31], el - 60, xl - xs);
        if (xl < xs) return round_single(lit[31], el - 60, xs - xl);
        return F_ZERO;
    endfunction

    function automatic t_word sub_single(input t_word a, input t_word b);
        return add_single(a, b ^ NEG_ZERO);
    endfunction

    function automatic t_word int_to_single(input int n);
        if (n == 0) return F_ZERO;
        return round_single(n < 0, 0, 128'((n < 0) ? -n : n));
    endfunction

    function automatic t_word exp_single(input t_word xin);
        t_word x;
        t_word fx;
        t_word tf;
        t_word y;
        t_word z;
        t_word coef[6];
        int    n;
        int    biased;
        coef = '{EP0, EP1, EP2, EP3, EP4, EP5};
        if (is_nan(xin)) return QNAN_BITS;
        x = xin;
        if (single_value(x) > single_value(EXP_HI)) x = EXP_HI;
        if (single_value(x) < single_value(EXP_LO)) x = EXP_LO;
        fx = add_single(mul_single(x, LOG2E), F_HALF);
        tf = int_to_single($rtoi(single_value(fx)));
        fx = (single_value(tf) > single_value(fx)) ? sub_single(tf, F_ONE)
                                                   : sub_single(tf, F_ZERO);
        x = sub_single(x, mul_single(fx, RED_C1));
        x = sub_single(x, mul_single(fx, RED_C2));
        y = mul_single(coef[0], x);
        z = mul_single(x, x);
        for (int i = 1; i < 6; i++) begin
            y = add_single(y, coef[i]);
            if (i < 5) y = mul_single(y, x);
        end
        y = mul_single(y, z);
        y = add_single(y, x);
        y = add_single(y, F_ONE);
        n = $rtoi(single_value(fx));
        biased = n + 127;
        if (biased < 0) biased = 0;
        if (biased > 255) biased = 255;
        return mul_single(y, {1'b0, 8'(biased), 23'b0});
    endfunction

    function automatic t_word log_single(input t_word w);
        t_word x;
        t_word e;
        t_word keep;
        t_word y;
        t_word z;
        t_word coef[9];
        logic  below;
        coef = '{LP0, LP1, LP2, LP3, LP4, LP5, LP6, LP7, LP8};
        if (w[31] || w[30:23] == '0) return ALL_ONES;
        if (w[30:23] == 8'hFF) return (w[22:0] != '0) ? ALL_ONES : PINF_BITS;
        x     = {9'b0_0111_1110, w[22:0]};
        e     = add_single(int_to_single(int'(w[30:23]) - 127), F_ONE);
        below = single_value(x) < single_value(SQRT_HALF);
        keep  = below ? x : F_ZERO;
        x     = sub_single(x, F_ONE);
        e     = sub_single(e, below ? F_ONE : F_ZERO);
        x     = add_single(x, keep);
        z     = mul_single(x, x);
        y     = coef[0];
        for (int i = 1; i < 9; i++) begin
            y = mul_single(y, x);
            y = add_single(y, coef[i]);
        end
        y = mul_single(y, x);
        y = mul_single(y, z);
        y = add_single(y, mul_single(e, RED_C2));
        y = sub_single(y, mul_single(z, F_HALF));
        x = add_single(x, y);
        return add_single(x, mul_single(e, RED_C1));
    endfunction

    function automatic t_answer predict_answer(input t_request rq);
        t_answer an;
        an.last_out = rq.last_in;
        case (rq.command)
            CMD_EXP: an.result_bits = exp_single(rq.operand_a);
            CMD_LOG: an.result_bits = log_single(rq.operand_a);
            CMD_POW: an.result_bits =
                exp_single(mul_single(rq.operand_b, log_single(rq.operand_a)));
            default: an.result_bits = ALL_ONES;
        endcase
        return an;
    endfunction

    // Random single with the exponent field in a band around the bias.
    function automatic t_word rand_single(input int spread, input logic allow_neg);
        logic sgn;
        int   fe;
        sgn = allow_neg ? 1'($urandom_range(0, 1)) : 1'b0;
        fe  = 127 + int'($urandom_range(0, 2 * spread)) - spread;
        if (fe < 0) fe = 0;
        if (fe > 255) fe = 255;
        return {sgn, 8'(fe), 23'($urandom)};
    endfunction

    function automatic t_request rand_request();
        t_request rq;
        int       kind;
        kind         = $urandom_range(0, 99);
        rq.command   = (kind < 4) ? CMD_UNUSED : 2'($urandom_range(0, 2));
        rq.operand_a = $urandom;
        rq.operand_b = $urandom;
        rq.last_in   = 1'($urandom_range(0, 1));
        // Mostly in-range arguments so the polynomials see real work.
        if (kind >= 25) begin
            case (rq.command)
                CMD_EXP: rq.operand_a = rand_single(8, 1'b1);
                CMD_LOG: rq.operand_a = rand_single(60, kind < 35);
                CMD_POW: begin
                    rq.operand_a = rand_single(10, kind < 35);
                    rq.operand_b = rand_single(5, 1'b1);
                end
                default: ;
            endcase
        end
        return rq;
    endfunction

    function automatic t_request make_request(input logic [1:0] c, input t_word a,
                                              input t_word b, input logic l);
        t_request rq;
        rq.command   = c;
        rq.operand_a = a;
        rq.operand_b = b;
        rq.last_in   = l;
        return rq;
    endfunction

    function automatic int idle_phase();
        return (sent_count / PHASE_ITEMS) % 4;
    endfunction

    // Driver: present the next pending transaction at the falling edge.
    always @(negedge clk) begin
        int ph;
        ph = idle_phase();
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || in_taken) begin
                in_taken = 1'b0;
                if (pending_q.size() != 0 &&
                    !((ph == 1 && $urandom_range(0, 99) < 87) ||
                      (ph == 3 && $urandom_range(0, 99) < 11))) begin
                    t_request rq;
                    rq = pending_q.pop_front();
                    sent_count++;
                    in_ch.valid     <= 1'b1;
                    in_ch.command   <= rq.command;
                    in_ch.operand_a <= rq.operand_a;
                    in_ch.operand_b <= rq.operand_b;
                    in_ch.last_in   <= rq.last_in;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= !((ph == 2 && $urandom_range(0, 99) < 87) ||
                              (ph == 3 && $urandom_range(0, 99) < 11));
        end
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge clk) begin
        logic    fired;
        t_answer got;
        t_answer want;
        fired = 1'b0;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            answer_q.push_back(predict_answer(make_request(in_ch.command, in_ch.operand_a,
                                                           in_ch.operand_b, in_ch.last_in)));
            in_taken = 1'b1;
            fired = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            fired = 1'b1;
            got.result_bits = out_ch.result_bits;
            got.last_out    = out_ch.last_out;
            if (answer_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: result_bits %h last_out %b",
                             got.result_bits, got.last_out);
            end else begin
                want = answer_q.pop_front();
                if (got.result_bits !== want.result_bits || got.last_out !== want.last_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: result_bits exp %h got %h, last_out exp %b got %b",
                                 want.result_bits, got.result_bits, want.last_out,
                                 got.last_out);
                end
            end
        end
        // Watchdog on cycles without any transaction.
        if (!rst_n || fired) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.command   = CMD_EXP;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        in_ch.last_in   = 1'b0;
        out_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        in_taken        = 1'b0;
        sent_count      = 0;
        mismatch_count  = 0;
        stall_cycles    = 0;

        // Directed corners of exp, log and pow, and one unused command.
        pending_q.push_back(make_request(CMD_EXP, F_ZERO, '0, 1'b0));
        pending_q.push_back(make_request(CMD_EXP, F_ONE, '1, 1'b1));
        pending_q.push_back(make_request(CMD_EXP, PINF_BITS, '0, 1'b0));
        pending_q.push_back(make_request(CMD_EXP, 32'hFF80_0000, '0, 1'b1));
        pending_q.push_back(make_request(CMD_EXP, QNAN_BITS, '0, 1'b0));
        pending_q.push_back(make_request(CMD_EXP, EXP_HI, '0, 1'b0));
        pending_q.push_back(make_request(CMD_EXP, 32'hC2AE_0000, '0, 1'b0));
        pending_q.push_back(make_request(CMD_EXP, 32'hC2C8_0000, '0, 1'b1));
        pending_q.push_back(make_request(CMD_EXP, 32'h7F7F_FFFF, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, F_ZERO, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, NEG_ZERO, '0, 1'b1));
        pending_q.push_back(make_request(CMD_LOG, 32'h0000_0001, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, F_MONE, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, 32'h7FC0_0001, '0, 1'b1));
        pending_q.push_back(make_request(CMD_LOG, PINF_BITS, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, F_ONE, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, SQRT_HALF, '0, 1'b0));
        pending_q.push_back(make_request(CMD_LOG, 32'h7F7F_FFFF, '0, 1'b1));
        pending_q.push_back(make_request(CMD_LOG, 32'h0080_0000, '0, 1'b0));
        pending_q.push_back(make_request(CMD_POW, 32'h4000_0000, F_HALF, 1'b0));
        pending_q.push_back(make_request(CMD_POW, F_ZERO, F_ONE, 1'b1));
        pending_q.push_back(make_request(CMD_POW, F_MONE, F_HALF, 1'b0));
        pending_q.push_back(make_request(CMD_POW, 32'h4000_0000, PINF_BITS, 1'b0));
        pending_q.push_back(make_request(CMD_POW, 32'h7F7F_FFFF, 32'h4120_0000, 1'b1));
        pending_q.push_back(make_request(CMD_UNUSED, '1, '1, 1'b1));
        for (int i = 0; i < 950; i++) pending_q.push_back(rand_request());

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || in_ch.valid || answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && answer_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/fel_pkg.sv
hdl/fel_if.sv
hdl/fel_entry.sv
hdl/fel_stage.sv
hdl/float_exp_log_pow_unit.sv
bench/testbench.sv
